// ===== hw/rtl/c8_pkg.sv =====
package c8_pkg;

  localparam int MEM_AW     = 12;
  localparam int FB_RW      = 5;
  localparam int SCREEN_W   = 64;
  localparam int FONT_BYTES = 80;

  localparam logic [MEM_AW-1:0] PROGRAM_BASE = 12'd512;
  localparam logic [MEM_AW-1:0] FONT_BASE    = 12'd80;
  localparam logic [MEM_AW-1:0] FONT_END     = FONT_BASE + 12'd80;

  localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_EXEC = 2'd1,
    ACT_TICK = 2'd2,
    ACT_ROW  = 2'd3
  } action_t;

  // major opcode nibble
  localparam logic [3:0] OP_SYS   = 4'h0;
  localparam logic [3:0] OP_JP    = 4'h1;
  localparam logic [3:0] OP_CALL  = 4'h2;
  localparam logic [3:0] OP_SEI   = 4'h3;
  localparam logic [3:0] OP_SNEI  = 4'h4;
  localparam logic [3:0] OP_SER   = 4'h5;
  localparam logic [3:0] OP_LDI   = 4'h6;
  localparam logic [3:0] OP_ADDI  = 4'h7;
  localparam logic [3:0] OP_ALU   = 4'h8;
  localparam logic [3:0] OP_SNER  = 4'h9;
  localparam logic [3:0] OP_LDIDX = 4'hA;
  localparam logic [3:0] OP_JPV0  = 4'hB;
  localparam logic [3:0] OP_RND   = 4'hC;
  localparam logic [3:0] OP_DRW   = 4'hD;
  localparam logic [3:0] OP_SKP   = 4'hE;
  localparam logic [3:0] OP_MISC  = 4'hF;

  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  localparam logic [15:0] SYS_CLS = 16'h00E0;
  localparam logic [15:0] SYS_RET = 16'h00EE;

  localparam logic [7:0] SKP_DOWN = 8'h9E;
  localparam logic [7:0] SKP_UP   = 8'hA1;

  localparam logic [7:0] F_LDDT  = 8'h07;
  localparam logic [7:0] F_WAITK = 8'h0A;
  localparam logic [7:0] F_SETDT = 8'h15;
  localparam logic [7:0] F_SETST = 8'h18;
  localparam logic [7:0] F_ADDI  = 8'h1E;
  localparam logic [7:0] F_FONT  = 8'h29;
  localparam logic [7:0] F_BCD   = 8'h33;
  localparam logic [7:0] F_STORE = 8'h55;
  localparam logic [7:0] F_LOAD  = 8'h65;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DISP, S_ROW, S_F1, S_F2, S_R1, S_R2, S_EXEC, S_WF,
    S_DRD, S_DWR, S_BCD, S_M55RD, S_M55WR, S_M65RD, S_M65WR, S_FIN
  } state_t;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  typedef struct packed {
    logic       we;
    logic [3:0] waddr;
    logic [7:0] wdata;
    logic [3:0] raddr;
  } rf_req_t;

  typedef struct packed {
    logic                clear;
    logic                we;
    logic [FB_RW-1:0]    waddr;
    logic [SCREEN_W-1:0] wdata;
    logic [FB_RW-1:0]    raddr;
  } fb_req_t;

endpackage

// ===== hw/rtl/c8_mem.sv =====
module c8_mem import c8_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output logic [7:0] rdata
);

  logic [7:0] mem [2**MEM_AW];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

// ===== hw/rtl/c8_regfile.sv =====
module c8_regfile import c8_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  rf_req_t    req,
  output logic [7:0] rdata
);

  logic [7:0]  mem [16];
  logic [15:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (req.we) begin
      vld[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // write-through on same-entry access
  always_ff @(posedge clk) begin
    if (req.we && (req.waddr == req.raddr)) begin
      rdata <= req.wdata;
    end else begin
      rdata <= vld[req.raddr] ? mem[req.raddr] : 8'h00;
    end
  end

endmodule

// ===== hw/rtl/c8_fbuf.sv =====
module c8_fbuf import c8_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  fb_req_t             req,
  output logic [SCREEN_W-1:0] rdata
);

  logic [SCREEN_W-1:0] mem [2**FB_RW];
  logic [2**FB_RW-1:0] vld;

  // clear drops all valid bits at once
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      vld <= '0;
    end else if (req.we) begin
      vld[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= vld[req.raddr] ? mem[req.raddr] : '0;
  end

endmodule

// ===== hw/rtl/chip8_cpu_core_unit.sv =====
// Channel | Handshake            | Payload
// in      | in_valid / in_ready  | action, address, load_byte, keypad, random_byte
// out     | out_valid / out_ready| program_counter, opcode_done, key_wait, sound_on,
//         |                      | delay_value, flag_reg, display_row
//
// One item at a time through a sequencer around a 4 KB byte RAM (one port),
// a 16x8 register RAM and a 32x64 display RAM, all with registered reads.
// Execute fetches two opcode bytes, reads Vx then Vy, may write VF; a draw reads
// and writes each sprite row; Fx55/Fx65 move one register at a time; BCD writes
// three digits. The single RAM port and the one-read register RAM serialise these.
// Reset: a clear pass writes the font and zeros into the byte RAM;
// in_ready stays low until it ends.
// Stalls: a result sits in the output register; the next item is accepted
// meanwhile, and only the final step waits for the output to drain.
module chip8_cpu_core_unit import c8_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [11:0] address,
  input  logic [7:0]  load_byte,
  input  logic [15:0] keypad,
  input  logic [7:0]  random_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] program_counter,
  output logic [15:0] opcode_done,
  output logic        key_wait,
  output logic        sound_on,
  output logic [7:0]  delay_value,
  output logic [7:0]  flag_reg,
  output logic [63:0] display_row
);

  state_t state, state_next;

  // latched item
  logic [1:0]  it_action;
  logic [11:0] it_addr;
  logic [7:0]  it_byte;
  logic [15:0] it_keys;
  logic [7:0]  it_rnd;

  // architectural state kept in flops
  logic [11:0] pc, ireg;
  logic [3:0]  sp, ktarget;
  logic [11:0] stack [16];
  logic [7:0]  dt, st, vf;
  logic        waiting;

  // working registers
  logic [15:0] op, done_q;
  logic [7:0]  a, b;
  logic [3:0]  cnt;
  logic        flag;
  logic [63:0] row_q;
  logic [11:0] clr_cnt;

  mem_req_t    mem_req;
  rf_req_t     rf_req;
  fb_req_t     fb_req;
  logic [7:0]  mem_rdata, rf_rdata;
  logic [63:0] fb_rdata;

  c8_mem     u_mem (.clk(clk), .req(mem_req), .rdata(mem_rdata));
  c8_regfile u_rf  (.clk(clk), .rst(rst), .req(rf_req), .rdata(rf_rdata));
  c8_fbuf    u_fb  (.clk(clk), .rst(rst), .req(fb_req), .rdata(fb_rdata));

  logic [3:0]  major, x, y, n;
  logic [7:0]  kk;
  logic [11:0] nnn;
  assign major = op[15:12];
  assign x     = op[11:8];
  assign y     = op[7:4];
  assign n     = op[3:0];
  assign kk    = op[7:0];
  assign nnn   = op[11:0];

  // font byte for the clear pass
  logic [7:0] clr_data;
  assign clr_data = (clr_cnt >= FONT_BASE && clr_cnt < FONT_END) ?
                    FONT_ROM[7'(clr_cnt - FONT_BASE)] : 8'h00;

  // lowest pressed key
  logic [3:0] low_key;
  always_comb begin
    low_key = 4'h0;
    for (int k = 15; k >= 0; k--) begin
      if (it_keys[k]) low_key = 4'(k);
    end
  end

  // BCD digits: hundreds by compare, tens by reciprocal of ten
  logic [1:0]  bcd_h;
  logic [6:0]  bcd_rem;
  logic [14:0] bcd_prod;
  logic [3:0]  bcd_t, bcd_o;
  logic [7:0]  bcd_digit;
  always_comb begin
    bcd_h    = (a >= 8'd200) ? 2'd2 : ((a >= 8'd100) ? 2'd1 : 2'd0);
    bcd_rem  = 7'(a - 8'(bcd_h) * 8'd100);
    bcd_prod = 15'(bcd_rem) * 15'd205;
    bcd_t    = bcd_prod[14:11];
    bcd_o    = 4'(bcd_rem - 7'(bcd_t) * 7'd10);
    unique case (cnt[1:0])
      2'd0:    bcd_digit = {6'h0, bcd_h};
      2'd1:    bcd_digit = {4'h0, bcd_t};
      default: bcd_digit = {4'h0, bcd_o};
    endcase
  end

  // sprite row against display row
  logic [5:0]  row_sum;
  logic [63:0] sprite;
  logic        coll, draw_last;
  assign row_sum   = {1'b0, b[4:0]} + {2'b0, cnt};
  assign sprite    = {mem_rdata, 56'h0} >> a[5:0];
  assign coll      = |(fb_rdata & sprite);
  assign draw_last = (row_sum[4:0] == 5'd31) || (cnt == n - 4'd1);

  // instruction decode for the execute step
  logic [11:0] pc2, pc4, exec_pc;
  logic        exec_wr, exec_flag, exec_fwr, key_hit;
  logic [7:0]  exec_val;
  logic [8:0]  sum9;
  assign pc2     = pc + 12'd2;
  assign pc4     = pc + 12'd4;
  assign key_hit = it_keys[a[3:0]];
  assign sum9    = {1'b0, a} + {1'b0, b};

  always_comb begin
    exec_pc   = pc2;
    exec_wr   = 1'b0;
    exec_val  = 8'h00;
    exec_flag = 1'b0;
    exec_fwr  = 1'b0;
    unique case (major)
      OP_SYS:   if (op == SYS_RET) exec_pc = stack[sp - 4'd1];
      OP_JP:    exec_pc = nnn;
      OP_CALL:  exec_pc = nnn;
      OP_SEI:   if (a == kk) exec_pc = pc4;
      OP_SNEI:  if (a != kk) exec_pc = pc4;
      OP_SER:   if (a == b) exec_pc = pc4;
      OP_LDI:   begin exec_wr = 1'b1; exec_val = kk; end
      OP_ADDI:  begin exec_wr = 1'b1; exec_val = a + kk; end
      OP_ALU: begin
        unique case (n)
          ALU_MOV: begin exec_wr = 1'b1; exec_val = b; end
          ALU_OR:  begin exec_wr = 1'b1; exec_val = a | b; end
          ALU_AND: begin exec_wr = 1'b1; exec_val = a & b; end
          ALU_XOR: begin exec_wr = 1'b1; exec_val = a ^ b; end
          ALU_ADD: begin
            exec_wr = 1'b1; exec_val = sum9[7:0];
            exec_fwr = 1'b1; exec_flag = sum9[8];
          end
          ALU_SUB: begin
            exec_wr = 1'b1; exec_val = a - b;
            exec_fwr = 1'b1; exec_flag = (a >= b);
          end
          ALU_SHR: begin
            exec_wr = 1'b1; exec_val = {1'b0, a[7:1]};
            exec_fwr = 1'b1; exec_flag = a[0];
          end
          ALU_SUBN: begin
            exec_wr = 1'b1; exec_val = b - a;
            exec_fwr = 1'b1; exec_flag = (b >= a);
          end
          ALU_SHL: begin
            exec_wr = 1'b1; exec_val = {a[6:0], 1'b0};
            exec_fwr = 1'b1; exec_flag = a[7];
          end
          default: ;
        endcase
      end
      OP_SNER:  if (a != b) exec_pc = pc4;
      OP_LDIDX: ;
      OP_JPV0:  exec_pc = nnn + {4'h0, b};  // b holds V0 for this op
      OP_RND:   begin exec_wr = 1'b1; exec_val = kk & it_rnd; end
      OP_DRW:   ;
      OP_SKP: begin
        if (kk == SKP_DOWN && key_hit) exec_pc = pc4;
        if (kk == SKP_UP && !key_hit) exec_pc = pc4;
      end
      OP_MISC:  if (kk == F_LDDT) begin exec_wr = 1'b1; exec_val = dt; end
    endcase
  end

  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_req    = '0;
    rf_req     = '0;
    fb_req     = '0;
    unique case (state)
      S_CLR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = clr_cnt;
        mem_req.wdata = clr_data;
        if (clr_cnt == 12'hFFF) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = S_DISP;
      end
      S_DISP: begin
        unique case (action_t'(it_action))
          ACT_LOAD: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = it_addr;
            mem_req.wdata = it_byte;
            state_next    = S_FIN;
          end
          ACT_EXEC: begin
            if (waiting) begin
              rf_req.we    = (it_keys != 16'h0);
              rf_req.waddr = ktarget;
              rf_req.wdata = {4'h0, low_key};
              state_next   = S_FIN;
            end else begin
              mem_req.addr = pc;
              state_next   = S_F1;
            end
          end
          ACT_TICK: state_next = S_FIN;
          ACT_ROW: begin
            fb_req.raddr = it_addr[4:0];
            state_next   = S_ROW;
          end
        endcase
      end
      S_ROW: state_next = S_FIN;
      S_F1: begin
        mem_req.addr = pc + 12'd1;
        state_next   = S_F2;
      end
      S_F2: begin
        rf_req.raddr = op[11:8];
        state_next   = S_R1;
      end
      S_R1: begin
        rf_req.raddr = (major == OP_JPV0) ? 4'h0 : y;
        state_next   = S_R2;
      end
      S_R2: state_next = S_EXEC;
      S_EXEC: begin
        rf_req.we    = exec_wr;
        rf_req.waddr = x;
        rf_req.wdata = exec_val;
        fb_req.clear = (op == SYS_CLS);
        state_next   = exec_fwr ? S_WF : S_FIN;
        if (major == OP_DRW) state_next = (n == 4'h0) ? S_WF : S_DRD;
        if (major == OP_MISC) begin
          if (kk == F_BCD)   state_next = S_BCD;
          if (kk == F_STORE) state_next = S_M55RD;
          if (kk == F_LOAD)  state_next = S_M65RD;
        end
      end
      S_WF: begin
        rf_req.we    = 1'b1;
        rf_req.waddr = 4'hF;
        rf_req.wdata = {7'h0, flag};
        state_next   = S_FIN;
      end
      S_DRD: begin
        mem_req.addr = ireg + {8'h0, cnt};
        fb_req.raddr = row_sum[4:0];
        state_next   = S_DWR;
      end
      S_DWR: begin
        fb_req.we    = 1'b1;
        fb_req.waddr = row_sum[4:0];
        fb_req.wdata = fb_rdata ^ sprite;
        state_next   = draw_last ? S_WF : S_DRD;
      end
      S_BCD: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = ireg + {8'h0, cnt};
        mem_req.wdata = bcd_digit;
        if (cnt == 4'd2) state_next = S_FIN;
      end
      S_M55RD: begin
        rf_req.raddr = cnt;
        state_next   = S_M55WR;
      end
      S_M55WR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = ireg + {8'h0, cnt};
        mem_req.wdata = rf_rdata;
        state_next    = (cnt == x) ? S_FIN : S_M55RD;
      end
      S_M65RD: begin
        mem_req.addr = ireg + {8'h0, cnt};
        state_next   = S_M65WR;
      end
      S_M65WR: begin
        rf_req.we    = 1'b1;
        rf_req.waddr = cnt;
        rf_req.wdata = mem_rdata;
        state_next   = (cnt == x) ? S_FIN : S_M65RD;
      end
      S_FIN: if (out_free) state_next = S_IDLE;
    endcase
  end

  // datapath and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= PROGRAM_BASE;
      ireg    <= '0;
      sp      <= '0;
      dt      <= '0;
      st      <= '0;
      vf      <= '0;
      waiting <= 1'b0;
      ktarget <= '0;
      clr_cnt <= '0;
      for (int i = 0; i < 16; i++) stack[i] <= '0;
    end else begin
      if (state == S_CLR) clr_cnt <= clr_cnt + 12'd1;
      // VF mirror follows every register write to entry F
      if (rf_req.we && rf_req.waddr == 4'hF) vf <= rf_req.wdata;
      if (state == S_DISP) begin
        if (action_t'(it_action) == ACT_TICK) begin
          if (dt != 8'h0) dt <= dt - 8'd1;
          if (st != 8'h0) st <= st - 8'd1;
        end
        if (action_t'(it_action) == ACT_EXEC && waiting && it_keys != 16'h0) begin
          waiting <= 1'b0;
        end
      end
      if (state == S_EXEC) begin
        pc <= exec_pc;
        if (op == SYS_RET) sp <= sp - 4'd1;
        if (major == OP_CALL) begin
          stack[sp] <= pc2;
          sp        <= sp + 4'd1;
        end
        if (major == OP_LDIDX) ireg <= nnn;
        if (major == OP_MISC) begin
          unique case (kk)
            F_WAITK: begin waiting <= 1'b1; ktarget <= x; end
            F_SETDT: dt <= a;
            F_SETST: st <= a;
            F_ADDI:  ireg <= ireg + {4'h0, a};
            F_FONT:  ireg <= FONT_BASE + {6'h0, a[3:0], 2'b0} + {8'h0, a[3:0]};
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      it_action <= action;
      it_addr   <= address;
      it_byte   <= load_byte;
      it_keys   <= keypad;
      it_rnd    <= random_byte;
      done_q    <= '0;
      row_q     <= '0;
    end
    unique case (state)
      S_ROW:  row_q <= fb_rdata;
      S_F1:   op[15:8] <= mem_rdata;
      S_F2:   op[7:0] <= mem_rdata;
      S_R1:   a <= rf_rdata;
      S_R2:   b <= rf_rdata;
      S_EXEC: begin
        done_q <= op;
        cnt    <= '0;
        flag   <= exec_flag;  // also clears the collision flag for a draw
      end
      S_DWR: begin
        flag <= flag | coll;
        cnt  <= cnt + 4'd1;
      end
      S_BCD, S_M55WR, S_M65WR: cnt <= cnt + 4'd1;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      program_counter <= pc;
      opcode_done     <= done_q;
      key_wait        <= waiting;
      sound_on        <= (st != 8'h0);
      delay_value     <= dt;
      flag_reg        <= vf;
      display_row     <= row_q;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DISP))
    else $error("sequencer did not start on accepted item");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_req.we)
    else $error("byte RAM written while idle");

  a_draw_row_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DWR) |-> (cnt < n))
    else $error("sprite row count overran");

  a_clear_no_output: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> (!out_valid && !in_ready))
    else $error("traffic during clear pass");

endmodule
